### src/ogka_pkg.sv
// Shared constants and codes for the occupancy grid keypoint admission block.
// No dependencies; imported by occupancy_grid_keypoint_admission.
`timescale 1ns / 1ps
`default_nettype none

package ogka_pkg;

    // grid edge length in cells (1 to 64)
    localparam int GRID_SIZE  = 8;
    localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
    localparam int IDX_W      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int GRID_W     = $clog2(GRID_SIZE + 1);

    localparam int OP_W       = 2;
    localparam int POS_W      = 16;
    localparam int FRAC_W     = 4;
    localparam int DIM_W      = 13;
    localparam int LIMIT_W    = 8;
    localparam int COUNT_W    = 8;
    localparam int STATUS_W   = 3;
    localparam int CELL_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    // divider widths: numerator pos*GRID_SIZE, divisor dim*16 shifted by CELL_W
    localparam int NUM_W      = POS_W + GRID_W;
    localparam int DEN_W      = DIM_W + FRAC_W;
    localparam int DSH_W      = DEN_W + CELL_W;
    localparam int CMP_W      = (NUM_W > DSH_W) ? NUM_W : DSH_W;
    localparam int STEP_W     = $clog2(CELL_W + 1);
    localparam int ADDR_W     = 2 * CELL_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [CELL_W-1:0]  CELL_MAX  = '1;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(640);
    localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(480);
    localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_TRACK = 2'd1,
        OP_OFFER = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 3'd0,
        ST_ADMITTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_OUTSIDE  = 3'd3,
        ST_FAULT    = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_LIMIT  = 2'd2,
        REG_SPARE  = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

### src/occupancy_grid_keypoint_admission.sv
// Occupancy grid keypoint admission: serial cell divider, count memory, sequencer.
// Depends on ogka_pkg.
//
// Usage:
//   Command channel: an item (operation, x_position, y_position) is taken at a
//   rising edge with start high and busy low. One result per item appears on
//   status, cell_column and cell_row for a single cycle with done high; the
//   receiver cannot hold it off.
//   Clear and the unused operation finish at the accept edge itself: done is
//   high in the next cycle and busy never rises.
//   Track and offer items pass through the divider and the count memory: one shared
//   restoring compare/subtract unit runs 7 steps per axis (one saturation
//   check, then 6 quotient bits), x then y, followed by a read of the
//   count memory and an update of it. busy stays high until done rises;
//   the next item can be started in the cycle done is high.
//   Config: cfg_write_enable, cfg_index, cfg_data write the image width (0),
//   image height (1) or max_per_cell (2) at once; write only while idle.
//   Reset: asynchronous, active low; registers go to 640 / 480 / 1, the grid
//   reads all zero at once (per-cell valid bits), no sweep is needed.
`timescale 1ns / 1ps
`default_nettype none

module occupancy_grid_keypoint_admission
    import ogka_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output      logic                  busy,
    input  wire logic [OP_W-1:0]       operation,
    input  wire logic [POS_W-1:0]      x_position,
    input  wire logic [POS_W-1:0]      y_position,
    input  wire logic                  cfg_write_enable,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output      logic                  done,
    output      logic [STATUS_W-1:0]   status,
    output      logic [CELL_W-1:0]     cell_column,
    output      logic [CELL_W-1:0]     cell_row
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_UPDATE
    } state_t;

    state_t                state_reg;
    op_t                   op_reg;
    logic [POS_W-1:0]      y_pos_reg;
    logic [CMP_W-1:0]      rem_reg;
    logic [CMP_W-1:0]      dsh_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CELL_W-1:0]     quot_reg;
    logic                  sat_reg;
    logic                  axis_reg;
    logic [CELL_W-1:0]     col_reg;
    logic [CELL_W-1:0]     row_reg;
    logic                  col_in_reg;
    logic                  row_in_reg;
    logic [DIM_W-1:0]      width_reg;
    logic [DIM_W-1:0]      height_reg;
    logic [LIMIT_W-1:0]    limit_reg;
    status_t               status_reg;
    logic [CELL_W-1:0]     cell_column_reg;
    logic [CELL_W-1:0]     cell_row_reg;
    logic                  done_reg;

    logic [COUNT_W-1:0]    mem [CELL_COUNT];
    logic [CELL_COUNT-1:0] valid_reg;
    logic [COUNT_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;

    op_t                   op_in;
    logic                  ge;
    logic [CELL_W-1:0]     quot_fin;
    logic [CELL_W-1:0]     axis_val;
    logic                  axis_in;
    logic [IDX_W-1:0]      addr;
    logic [COUNT_W-1:0]    count;
    logic                  in_grid;
    logic                  can_inc;
    logic                  admit;
    logic                  mem_we;
    logic                  clear_all;
    logic                  accept;

    assign op_in  = op_t'(operation);
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    // shared unit: remainder against divisor shifted to the current bit
    assign ge       = (rem_reg >= dsh_reg);
    assign quot_fin = {quot_reg[CELL_W-2:0], ge};
    assign axis_val = sat_reg ? CELL_MAX : quot_fin;
    assign axis_in  = !sat_reg && ({1'b0, quot_fin} < (CELL_W + 1)'(GRID_SIZE));

    assign addr = IDX_W'(ADDR_W'(row_reg) * ADDR_W'(GRID_SIZE) + ADDR_W'(col_reg));

    assign count   = rd_valid_reg ? rd_data_reg : '0;
    assign in_grid = col_in_reg && row_in_reg;
    assign can_inc = (count != COUNT_MAX);
    assign admit   = (count < limit_reg);

    always_comb
    begin
        mem_we = 1'b0;
        if (state_reg == S_UPDATE && in_grid && can_inc)
        begin
            case (op_reg)
                OP_TRACK: mem_we = 1'b1;
                OP_OFFER: mem_we = admit;
                default:  mem_we = 1'b0;
            endcase
        end
    end

    assign clear_all = accept && (op_in == OP_CLEAR);

    // count memory: data without reset, validity in flops
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= count + COUNT_W'(1);
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (mem_we)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (state_reg == S_READ)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_NONE;
            y_pos_reg       <= '0;
            rem_reg         <= '0;
            dsh_reg         <= '0;
            step_reg        <= '0;
            quot_reg        <= '0;
            axis_reg        <= 1'b0;
            sat_reg         <= 1'b0;
            col_reg         <= '0;
            row_reg         <= '0;
            col_in_reg      <= 1'b0;
            row_in_reg      <= 1'b0;
            width_reg       <= WIDTH_RST;
            height_reg      <= HEIGHT_RST;
            limit_reg       <= LIMIT_RST;
            status_reg      <= ST_DONE;
            cell_column_reg <= '0;
            cell_row_reg    <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            // clear and unused op answer right after accept, others after update
            done_reg <= (state_reg == S_UPDATE) ||
                        (accept && op_in != OP_TRACK && op_in != OP_OFFER);

            if (cfg_write_enable)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:  width_reg  <= cfg_data[DIM_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[DIM_W-1:0];
                    REG_LIMIT:  limit_reg  <= cfg_data[LIMIT_W-1:0];
                    default:    ;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg    <= op_in;
                        y_pos_reg <= y_position;
                        case (op_in)
                            OP_TRACK, OP_OFFER:
                            begin
                                rem_reg   <= CMP_W'(x_position) * CMP_W'(GRID_SIZE);
                                dsh_reg   <= CMP_W'({width_reg, (FRAC_W + CELL_W)'(0)});
                                step_reg  <= STEP_W'(CELL_W);
                                quot_reg  <= '0;
                                sat_reg   <= 1'b0;
                                axis_reg  <= 1'b0;
                                state_reg <= S_DIV;
                            end
                            default:
                            begin
                                // clear or unused op: answer at once
                                status_reg      <= ST_DONE;
                                cell_column_reg <= '0;
                                cell_row_reg    <= '0;
                            end
                        endcase
                    end
                end

                S_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        // last quotient bit is taken from quot_fin directly
                        if (!axis_reg)
                        begin
                            col_reg    <= axis_val;
                            col_in_reg <= axis_in;
                            rem_reg    <= CMP_W'(y_pos_reg) * CMP_W'(GRID_SIZE);
                            dsh_reg    <= CMP_W'({height_reg, (FRAC_W + CELL_W)'(0)});
                            step_reg   <= STEP_W'(CELL_W);
                            quot_reg   <= '0;
                            sat_reg    <= 1'b0;
                            axis_reg   <= 1'b1;
                        end
                        else
                        begin
                            row_reg    <= axis_val;
                            row_in_reg <= axis_in;
                            state_reg  <= S_READ;
                        end
                    end
                    else
                    begin
                        dsh_reg  <= dsh_reg >> 1;
                        step_reg <= step_reg - STEP_W'(1);
                        if (step_reg == STEP_W'(CELL_W))
                        begin
                            // quotient of 64 or more (or zero divisor) only clips
                            sat_reg <= ge;
                        end
                        else
                        begin
                            quot_reg <= quot_fin;
                            if (ge)
                            begin
                                rem_reg <= rem_reg - dsh_reg;
                            end
                        end
                    end
                end

                S_READ:
                begin
                    state_reg <= S_UPDATE;
                end

                S_UPDATE:
                begin
                    cell_column_reg <= col_reg;
                    cell_row_reg    <= row_reg;
                    state_reg       <= S_IDLE;
                    if (op_reg == OP_TRACK)
                    begin
                        status_reg <= in_grid ? ST_DONE : ST_FAULT;
                    end
                    else if (!in_grid)
                    begin
                        status_reg <= ST_OUTSIDE;
                    end
                    else
                    begin
                        status_reg <= admit ? ST_ADMITTED : ST_FULL;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign cell_column = cell_column_reg;
    assign cell_row    = cell_row_reg;

endmodule

`default_nettype wire
